### rtl/core/vertex_transform_4x4_macros.svh
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising clock edge outside reset.
`define VT4_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vt4 assertion failed");

// Check that a condition never holds outside reset.
`define VT4_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vt4 forbidden condition seen");

`else

`define VT4_ASSERT(lbl, clk, rst_n, prop)
`define VT4_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/core/vt4_pkg.sv
// Types and constants shared by the vertex transform modules.
`default_nettype none

package vt4_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DIM     = 4;
  localparam int unsigned ENTRIES = DIM * DIM;
  localparam int unsigned IDX_W   = 4;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XFORM = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] entry_index;
    word_t            entry_value;
    word_t            vertex_x;
    word_t            vertex_y;
    word_t            vertex_z;
    word_t            vertex_w;
  } in_item_t;

  typedef struct packed {
    word_t out_x;
    word_t out_y;
    word_t out_z;
    word_t out_w;
    logic  saturated;
  } out_item_t;

  // Classified item as it waits between front and back
  typedef struct packed {
    logic                       is_load;
    logic [IDX_W-1:0]           idx;
    logic [DATA_W-1:0]          value;
    logic [DIM-1:0][DATA_W-1:0] vertex;
  } op_t;

endpackage

`default_nettype wire

### rtl/core/vt4_if.sv
// Valid/ready channel interfaces for vertex transform items and results.
`default_nettype none

interface vt4_in_if import vt4_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface vt4_out_if import vt4_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/vt4_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none

`include "vertex_transform_4x4_macros.svh"

module vt4_front import vt4_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_item_i,
  output logic          in_ready_o,
  input  wire logic     pop_i,
  output logic          head_valid_o,
  output op_t           head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  op_t              mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  op_t              op;

  // Classify the incoming item
  always_comb begin
    op.is_load   = (in_item_i.mode == MODE_LOAD);
    op.idx       = in_item_i.entry_index;
    op.value     = in_item_i.entry_value;
    op.vertex[0] = in_item_i.vertex_x;
    op.vertex[1] = in_item_i.vertex_y;
    op.vertex[2] = in_item_i.vertex_z;
    op.vertex[3] = in_item_i.vertex_w;
  end

  assign in_ready_o   = (count_q != CNT_FULL);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= op;
    end
  end

  `VT4_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_FULL)
  `VT4_ASSERT(a_no_pop_empty, clk_i, rst_ni, (count_q == '0) |-> !pop_i)
  `VT4_ASSERT(a_empty_ptrs, clk_i, rst_ni, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule

`default_nettype wire

### rtl/core/vt4_back.sv
// Back end: holds the matrix, applies loads and runs the transform pipeline.
`default_nettype none

`include "vertex_transform_4x4_macros.svh"

module vt4_back import vt4_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      head_valid_i,
  input  wire op_t       head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output out_item_t      out_item_o,
  input  wire logic      out_ready_i
);

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SH_W   = PROD_W - FRAC_BITS;
  localparam int unsigned PAIR_W = SH_W + 1;
  localparam int unsigned SUM_W  = SH_W + 2;
  localparam int unsigned TOP_W  = SUM_W - DATA_W + 1;
  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] MAX_FX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_FX = {1'b1, {(DATA_W-1){1'b0}}};

  word_t                    mat_q [ENTRIES];
  logic signed [PROD_W-1:0] prod_d [DIM][DIM];
  logic signed [PROD_W-1:0] prod_q [DIM][DIM];
  logic signed [SH_W-1:0]   sh [DIM][DIM];
  logic signed [PAIR_W-1:0] pair_d [DIM][2];
  logic signed [PAIR_W-1:0] pair_q [DIM][2];
  logic signed [SUM_W-1:0]  sum [DIM];
  logic [TOP_W-1:0]         top_bits [DIM];
  word_t                    res [DIM];
  logic [DIM-1:0]           ovf;
  logic                     s1_v_q, s2_v_q, out_v_q;
  logic                     s1_en, s2_en, s3_en;
  logic                     take_xform;
  out_item_t                out_d, out_q;

  // Tell whether any component of a result sits at a clip limit
  function automatic logic at_limit(input out_item_t item);
    return (item.out_x == MAX_FX) || (item.out_x == MIN_FX) ||
           (item.out_y == MAX_FX) || (item.out_y == MIN_FX) ||
           (item.out_z == MAX_FX) || (item.out_z == MIN_FX) ||
           (item.out_w == MAX_FX) || (item.out_w == MIN_FX);
  endfunction

  // Stage enables, from the output back
  assign s3_en      = !out_v_q || out_ready_i;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign pop_o      = head_valid_i && (head_i.is_load || s1_en);
  assign take_xform = pop_o && !head_i.is_load;

  // Matrix store: reset to identity, written by load items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        mat_q[i] <= ((i % (DIM + 1)) == 0) ? ONE_FX : '0;
      end
    end else if (pop_o && head_i.is_load) begin
      mat_q[head_i.idx] <= head_i.value;
    end
  end

  // Stage 1: sixteen products against the original vertex
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        prod_d[r][c] = mat_q[c * DIM + r] * $signed(head_i.vertex[c]);
      end
    end
  end

  // Stage 2: truncate products and add pairs
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        sh[r][c] = SH_W'(prod_q[r][c] >>> FRAC_BITS);
      end
      pair_d[r][0] = PAIR_W'(sh[r][0]) + PAIR_W'(sh[r][1]);
      pair_d[r][1] = PAIR_W'(sh[r][2]) + PAIR_W'(sh[r][3]);
    end
  end

  // Stage 3: final row sum and saturation
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      sum[r]      = SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]);
      top_bits[r] = sum[r][SUM_W-1:DATA_W-1];
      ovf[r]      = !((&top_bits[r]) || !(|top_bits[r]));
      if (ovf[r]) begin
        res[r] = sum[r][SUM_W-1] ? MIN_FX : MAX_FX;
      end else begin
        res[r] = sum[r][DATA_W-1:0];
      end
    end
    out_d.out_x     = res[0];
    out_d.out_y     = res[1];
    out_d.out_z     = res[2];
    out_d.out_w     = res[3];
    out_d.saturated = |ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= take_xform;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_en) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_xform) begin
      prod_q <= prod_d;
    end
    if (s2_en && s1_v_q) begin
      pair_q <= pair_d;
    end
    if (s3_en && s2_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  `VT4_ASSERT(a_s2_from_s1, clk_i, rst_ni, (s2_v_q && !$past(s2_v_q)) |-> $past(s1_v_q))
  `VT4_ASSERT(a_sat_extreme, clk_i, rst_ni, (out_v_q && out_q.saturated) |-> at_limit(out_q))

endmodule

`default_nettype wire

### rtl/core/vertex_transform_4x4.sv
// Top level of the 4x4 fixed-point vertex transform.
`default_nettype none

// Homogeneous 4x4 vertex transform in signed fixed point with FRAC_BITS
// fraction bits. A load item writes one entry of the column-major matrix
// (index = column*4 + row, identity after reset) and gives no result; it
// applies to every transform item accepted after it. A transform item returns
// the matrix times the vertex, each product truncated toward minus infinity,
// each row sum saturated to 32 bits with the saturated flag set if any row
// clipped. One item is accepted per cycle sustained while the output is not
// stalled; a transform item passes through the input queue, then the sixteen
// parallel multipliers, the pair adders, and the final add with saturation
// into the output register. The input queue holds QUEUE_DEPTH items so the
// input side keeps moving for a while when the output stalls.

module vertex_transform_4x4 import vt4_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vt4_in_if.sink     in_i,
  vt4_out_if.source  out_o
);

  logic      pop;
  logic      head_valid;
  op_t       head;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  vt4_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_item_i    (in_i.payload),
    .in_ready_o   (in_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  vt4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item),
    .out_ready_i  (out_o.ready)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule

`default_nettype wire
